@@ rtl/b58_pkg.sv @@
// Shared constants, types and the digit-to-character function of the base58 encoder.
`timescale 1ns / 1ps

package b58_pkg;

    localparam int MAX_BYTES   = 32;
    localparam int DIGIT_DEPTH = 44;
    localparam int ADDR_W      = $clog2(DIGIT_DEPTH);
    localparam int CNT_W       = 6;
    localparam int TOTAL_W     = CNT_W + 1;
    localparam int BYTE_W      = 8;
    localparam int CHAR_W      = 7;
    localparam int DIGIT_W     = 6;
    localparam int CARRY_W     = 8;
    localparam int PROD_IN_W   = DIGIT_W + BYTE_W;

    // Division by 58 as a multiply by the rounded-up reciprocal 2^21 / 58.
    localparam int                 RECIP_SHIFT = 21;
    localparam logic [15:0]        RECIP_58    = 16'd36158;
    localparam logic [PROD_IN_W-1:0] RADIX     = PROD_IN_W'(58);

    localparam logic [CHAR_W-1:0] CHAR_ONE = 7'd49;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD0,
        ST_WALK,
        ST_EXT,
        ST_FIN,
        ST_OUT_RD,
        ST_OUT_LD
    } t_state;

    typedef struct packed {
        logic take;
        logic rd_first;
        logic walk_step;
        logic ext_step;
        logic set_drop;
        logic fin;
        logic out_rd;
        logic out_load;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic dc_zero;
        logic j_last;
        logic carry_zero;
        logic store_full;
        logic taken_full;
        logic in_final;
        logic byte_final;
        logic k_last;
        logic out_free;
    } t_sts;

    // Bitcoin alphabet: digits, then capitals without I and O, then lower case without l.
    function automatic logic [CHAR_W-1:0] b58_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dd;
        dd = {1'b0, d};
        if (d < 6'd9) begin
            b58_char = 7'd49 + dd;
        end else if (d < 6'd17) begin
            b58_char = 7'd65 + dd - 7'd9;
        end else if (d < 6'd22) begin
            b58_char = 7'd74 + dd - 7'd17;
        end else if (d < 6'd33) begin
            b58_char = 7'd80 + dd - 7'd22;
        end else if (d < 6'd44) begin
            b58_char = 7'd97 + dd - 7'd33;
        end else begin
            b58_char = 7'd109 + dd - 7'd44;
        end
    endfunction

endpackage

@@ rtl/b58_if.sv @@
// Channel interfaces for message bytes in and encoded characters out.
`timescale 1ns / 1ps

interface b58_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_final;

    modport source (output valid, output in_byte, output is_final, input ready);
    modport sink   (input valid, input in_byte, input is_final, output ready);
endinterface

interface b58_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic       end_of_text;
    logic       overflow;

    modport source (output valid, output char_code, output end_of_text, output overflow,
                    input ready);
    modport sink   (input valid, input char_code, input end_of_text, input overflow,
                    output ready);
endinterface

@@ rtl/b58_ctrl.sv @@
// Sequencer that steps the datapath through absorb, carry extension and character output.
`timescale 1ns / 1ps

module b58_ctrl import b58_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_sts.taken_full) begin
                        n_state = i_sts.in_final ? ST_FIN : ST_IDLE;
                    end else if (i_sts.dc_zero) begin
                        n_state = ST_EXT;
                    end else begin
                        n_state = ST_RD0;
                    end
                end
            end
            ST_RD0: begin
                o_cmd.rd_first = 1'b1;
                n_state        = ST_WALK;
            end
            ST_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_sts.j_last) begin
                    n_state = ST_EXT;
                end
            end
            ST_EXT: begin
                if (i_sts.carry_zero) begin
                    n_state = i_sts.byte_final ? ST_FIN : ST_IDLE;
                end else if (i_sts.store_full) begin
                    // No room for the leftover carry: it is lost.
                    o_cmd.set_drop = 1'b1;
                    n_state        = i_sts.byte_final ? ST_FIN : ST_IDLE;
                end else begin
                    o_cmd.ext_step = 1'b1;
                end
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = ST_OUT_RD;
            end
            ST_OUT_RD: begin
                o_cmd.out_rd = 1'b1;
                n_state      = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.k_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        n_state = ST_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/b58_dp.sv @@
// Datapath: digit memory, divide-by-58 unit, message counters and the output register.
`timescale 1ns / 1ps

module b58_dp import b58_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_in_final,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CHAR_W-1:0] o_char_code,
    output logic              o_end_of_text,
    output logic              o_overflow
);

    logic [DIGIT_W-1:0] r_mem [DIGIT_DEPTH];
    logic [DIGIT_W-1:0] r_rdata;

    logic [CNT_W-1:0]   r_dc;
    logic [CNT_W-1:0]   r_zp;
    logic               r_in_zp;
    logic [CNT_W-1:0]   r_taken;
    logic               r_dropped;

    logic [CARRY_W-1:0] r_carry;
    logic               r_final;
    logic [CNT_W-1:0]   r_j;
    logic [CNT_W-1:0]   r_k;
    logic [CNT_W-1:0]   r_n;

    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_eot;
    logic               r_ovf;

    logic [PROD_IN_W-1:0]    div_x;
    logic [PROD_IN_W+15:0]   div_prod;
    logic [CARRY_W-1:0]      div_q;
    logic [PROD_IN_W-1:0]    div_rem_full;
    logic [DIGIT_W-1:0]      div_rem;

    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] pos_full;
    logic               taken_full;
    logic               k_last;
    logic               k_in_prefix;

    // Each walk step folds digit*256 plus the carry; extension steps split the carry alone.
    assign div_x = i_cmd.walk_step ? ({r_rdata, {BYTE_W{1'b0}}} + PROD_IN_W'(r_carry))
                                   : PROD_IN_W'(r_carry);
    assign div_prod     = div_x * RECIP_58;
    assign div_q        = div_prod[RECIP_SHIFT +: CARRY_W];
    assign div_rem_full = div_x - PROD_IN_W'(div_q) * RADIX;
    assign div_rem      = div_rem_full[DIGIT_W-1:0];

    assign taken_full  = r_taken >= CNT_W'(MAX_BYTES);
    assign k_last      = r_k == (r_n - CNT_W'(1));
    assign k_in_prefix = r_k < r_zp;
    assign total       = TOTAL_W'(r_zp) + TOTAL_W'(r_dc);
    // Digits leave most significant first, right after the run of leading '1's.
    assign pos_full    = TOTAL_W'(r_dc) + TOTAL_W'(r_zp) - TOTAL_W'(r_k) - TOTAL_W'(1);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_j[ADDR_W-1:0];
        if (i_cmd.rd_first) begin
            rd_en = 1'b1;
        end else if (i_cmd.walk_step) begin
            rd_en   = !o_sts.j_last;
            rd_addr = ADDR_W'(r_j + CNT_W'(1));
        end else if (i_cmd.out_rd) begin
            rd_en   = !k_in_prefix;
            rd_addr = pos_full[ADDR_W-1:0];
        end
    end

    assign wr_en   = i_cmd.walk_step | i_cmd.ext_step;
    assign wr_addr = i_cmd.walk_step ? r_j[ADDR_W-1:0] : r_dc[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= div_rem;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc      <= '0;
            r_zp      <= '0;
            r_in_zp   <= 1'b1;
            r_taken   <= '0;
            r_dropped <= 1'b0;
        end else if (i_cmd.clear) begin
            r_dc      <= '0;
            r_zp      <= '0;
            r_in_zp   <= 1'b1;
            r_taken   <= '0;
            r_dropped <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                if (!taken_full) begin
                    r_taken <= r_taken + CNT_W'(1);
                    if (r_in_zp && i_in_byte == '0) begin
                        r_zp <= r_zp + CNT_W'(1);
                    end else begin
                        r_in_zp <= 1'b0;
                    end
                end else begin
                    r_dropped <= 1'b1;
                end
            end
            if (i_cmd.ext_step) begin
                r_dc <= r_dc + CNT_W'(1);
            end
            if (i_cmd.set_drop) begin
                r_dropped <= 1'b1;
            end
            if (i_cmd.fin && total > TOTAL_W'(DIGIT_DEPTH)) begin
                r_dropped <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_carry <= taken_full ? '0 : i_in_byte;
            r_final <= i_in_final;
            r_j     <= '0;
        end
        if (i_cmd.walk_step) begin
            r_carry <= div_q;
            r_j     <= r_j + CNT_W'(1);
        end
        if (i_cmd.ext_step) begin
            r_carry <= div_q;
        end
        if (i_cmd.fin) begin
            r_k <= '0;
            r_n <= (total > TOTAL_W'(DIGIT_DEPTH)) ? CNT_W'(DIGIT_DEPTH) : total[CNT_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_k    <= r_k + CNT_W'(1);
            r_char <= k_in_prefix ? CHAR_ONE : b58_char(r_rdata);
            r_eot  <= k_last;
            r_ovf  <= r_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.dc_zero    = r_dc == '0;
        o_sts.j_last     = (r_j + CNT_W'(1)) == r_dc;
        o_sts.carry_zero = r_carry == '0;
        o_sts.store_full = r_dc >= CNT_W'(DIGIT_DEPTH);
        o_sts.taken_full = taken_full;
        o_sts.in_final   = i_in_final;
        o_sts.byte_final = r_final;
        o_sts.k_last     = k_last;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_char_code   = r_char;
    assign o_end_of_text = r_eot;
    assign o_overflow    = r_ovf;

endmodule

@@ rtl/base58_text_encoder.sv @@
// Top level of the base58 encoder: sequencer plus datapath behind two word channels.
//
//   Channel | Dir | Payload                              | Word
//   i_in    | in  | in_byte[7:0], is_final               | one message byte, MSB first
//   o_out   | out | char_code[6:0], end_of_text, overflow | one base58 character
//
// A byte is taken, the first stored digit is read, the walk over the digit memory goes one
// digit per cycle, and the leftover carry is then split into new digits; into an empty store
// the read and the walk are skipped. A byte past the size limit is taken and dropped.
// After the final byte a setup state runs, then each character takes one memory read and one
// load.
// Reset is synchronous and active low; it empties the digit store and clears the digit,
// zero-prefix and byte counts. A stalled output holds its word; the next byte is taken while the last character waits.
`timescale 1ns / 1ps

module base58_text_encoder import b58_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    b58_in_if.sink         i_in,
    b58_out_if.source      o_out
);

    t_cmd cmd;
    t_sts sts;

    b58_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    b58_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_in_byte     (i_in.in_byte),
        .i_in_final    (i_in.is_final),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_char_code   (o_out.char_code),
        .o_end_of_text (o_out.end_of_text),
        .o_overflow    (o_out.overflow)
    );

endmodule

@@ rtl/b58_checker.sv @@
// Port-level checks on the base58 encoder, bound to the top level.
`timescale 1ns / 1ps

module b58_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_final,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [6:0] i_out_char,
    input logic       i_out_eot
);

    // Nothing is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // Every character comes from the alphabet range.
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_char >= 7'd49 && i_out_char <= 7'd122))
        else $error("character code outside the alphabet");

    // A final byte starts the output phase, so no byte is taken in the next cycle.
    a_final_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_final) |=> !i_in_ready)
        else $error("byte accepted right after a final byte");

    // A byte that is not final produces no character.
    a_nonfinal_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid && i_in_valid && i_in_ready && !i_in_final) |=> !i_out_valid)
        else $error("character produced by a non-final byte");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_char)
                                           && $stable(i_out_eot)))
        else $error("stalled output word changed");

endmodule

bind base58_text_encoder b58_checker u_b58_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_final  (i_in.is_final),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.char_code),
    .i_out_eot   (o_out.end_of_text)
);

@@ bench/base58_text_encoder_tb.sv @@
// Self-checking testbench for the base58 text encoder: random and directed messages, scoreboard.
`timescale 1ns / 1ps

module base58_text_encoder_tb import b58_pkg::*; ();

    localparam string B58_ALPHABET =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
    localparam int B58_BASE      = 58;
    localparam int RANDOM_BYTES  = 210;
    localparam int DRAIN_CYCLES  = 120;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 10;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              eot;
        logic              ovf;
    } t_enc_char;

    class t_scoreboard;
        t_enc_char         expected_chars[$];
        logic [DIGIT_W-1:0] digits[DIGIT_DEPTH];
        int unsigned       n_digits;
        int unsigned       n_zero_lead;
        int unsigned       n_taken;
        bit                leading;
        bit                lost;
        int                errors;

        function new();
            errors = 0;
            clear_message();
        endfunction

        function void clear_message();
            foreach (digits[i]) digits[i] = '0;
            n_digits    = 0;
            n_zero_lead = 0;
            n_taken     = 0;
            leading     = 1'b1;
            lost        = 1'b0;
        endfunction

        // Multiplies the stored number by 256, adds the byte and, on a final
        // word, queues the characters of the whole message.
        function void note_byte(input logic [BYTE_W-1:0] b, input logic fin);
            int unsigned carry;
            int unsigned n_out;
            int unsigned pos;
            t_enc_char   c;
            if (n_taken < MAX_BYTES) begin
                n_taken++;
                if (leading && b == '0) begin
                    n_zero_lead++;
                end else begin
                    leading = 1'b0;
                end
                carry = b;
                for (int j = 0; j < int'(n_digits); j++) begin
                    carry += int'(digits[j]) * 256;
                    digits[j] = DIGIT_W'(carry % B58_BASE);
                    carry /= B58_BASE;
                end
                while (carry != 0) begin
                    if (n_digits >= DIGIT_DEPTH) begin
                        lost = 1'b1;
                        break;
                    end
                    digits[n_digits] = DIGIT_W'(carry % B58_BASE);
                    n_digits++;
                    carry /= B58_BASE;
                end
            end else begin
                lost = 1'b1;
            end
            if (!fin) return;
            n_out = n_zero_lead + n_digits;
            if (n_out > DIGIT_DEPTH) begin
                n_out = DIGIT_DEPTH;
                lost  = 1'b1;
            end
            for (int unsigned k = 0; k < n_out; k++) begin
                if (k < n_zero_lead) begin
                    c.code = CHAR_W'(B58_ALPHABET[0]);
                end else begin
                    pos    = n_digits - 1 - (k - n_zero_lead);
                    c.code = CHAR_W'(B58_ALPHABET[digits[pos % DIGIT_DEPTH]]);
                end
                c.eot = (k + 1 == n_out);
                c.ovf = lost;
                expected_chars = {expected_chars, c};
            end
            clear_message();
        endfunction

        function void check_char(input logic [CHAR_W-1:0] code, input logic eot,
                                 input logic ovf);
            t_enc_char exp_c;
            if (expected_chars.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected word: code=%0d eot=%0b ovf=%0b", code, eot, ovf);
                return;
            end
            exp_c = expected_chars.pop_front();
            if (exp_c.code !== code || exp_c.eot !== eot || exp_c.ovf !== ovf) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"mismatch: expected code=%0d eot=%0b ovf=%0b, ",
                              "got code=%0d eot=%0b ovf=%0b"},
                             exp_c.code, exp_c.eot, exp_c.ovf, code, eot, ovf);
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    b58_in_if  in_ch ();
    b58_out_if out_ch ();

    base58_text_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_scoreboard   sb;
    int            send_idle_pct;
    int            recv_stall_pct;
    int            bytes_sent;
    int            cycles;
    logic [7:0]    msg[$];

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_char(out_ch.char_code, out_ch.end_of_text, out_ch.overflow);
    end

    task automatic set_idle_mode(input t_idle_mode mode);
        case (mode)
            IDLE_SEND: begin
                send_idle_pct  = 54;
                recv_stall_pct = 0;
            end
            IDLE_RECV: begin
                send_idle_pct  = 0;
                recv_stall_pct = 54;
            end
            IDLE_BOTH: begin
                send_idle_pct  = 14;
                recv_stall_pct = 14;
            end
            default: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // Entered and left at a falling edge; valid stays high between back-to-back words.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_ch.valid    <= 1'b1;
        in_ch.in_byte  <= b;
        in_ch.is_final <= fin;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_byte(b, fin);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_message();
        foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
    endtask

    initial begin
        int len;
        int zeros;
        int pick;
        int msg_idx;
        sb             = new();
        cycles         = 0;
        bytes_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.in_byte  = '0;
        in_ch.is_final = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: single zero, extremes, the first two-digit value, zero prefixes.
        set_idle_mode(IDLE_NONE);
        msg = '{8'h00};                   send_message();
        msg = '{8'hFF};                   send_message();
        msg = '{8'h39};                   send_message();
        msg = '{8'h3A};                   send_message();
        msg = '{8'h00, 8'h00};            send_message();
        msg = '{8'h00, 8'h00, 8'h01};     send_message();
        msg = '{8'h01, 8'h00};            send_message();
        msg = '{8'h00, 8'hFF};            send_message();
        msg = '{8'h80, 8'h7F, 8'h55, 8'hAA}; send_message();

        // Random messages, mostly short; a few full-size and a few that overflow.
        msg_idx    = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            set_idle_mode(t_idle_mode'((msg_idx / 3) % 4));
            pick = $urandom_range(0, 99);
            if (pick < 70)      len = $urandom_range(1, 6);
            else if (pick < 85) len = $urandom_range(7, 20);
            else if (pick < 95) len = $urandom_range(21, MAX_BYTES);
            else                len = $urandom_range(MAX_BYTES + 1, MAX_BYTES + 8);
            pick  = $urandom_range(0, 99);
            zeros = 0;
            if (pick < 5)       zeros = len;
            else if (pick < 25) zeros = $urandom_range(1, (len < 4) ? len : 4);
            msg.delete();
            for (int i = 0; i < len; i++) begin
                if (i < zeros) msg = {msg, 8'h00};
                else if (pick >= 95 && pick < 98) msg = {msg, 8'hFF};
                else msg = {msg, 8'($urandom_range(0, 255))};
            end
            send_message();
            msg_idx++;
        end
        in_ch.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
